// ===== sv/sht_pkg.sv =====
package sht_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] TAG_EMPTY   = 2'd0;
  localparam logic [1:0] TAG_USED    = 2'd1;
  localparam logic [1:0] TAG_DELETED = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [31:0] PRIME_X = 32'd73856093;
  localparam logic [31:0] PRIME_Y = 32'd19349663;
  localparam logic [31:0] PRIME_Z = 32'd83492791;

  localparam int HASH_W = 32;

  typedef struct packed {
    logic load;
    logic mul;
    logic hash;
    logic mod_step;
    logic advance;
    logic finish;
    logic clear;
  } sht_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic term;
    logic last_probe;
    logic last_slot;
  } sht_stat_t;

endpackage

// ===== sv/sht_datapath.sv =====
module sht_datapath #(
  parameter int SLOTS      = 4096,
  parameter int COORD_BITS = 16,
  parameter int VALUE_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   in_op,
  input  logic signed [COORD_BITS-1:0] in_key_x,
  input  logic signed [COORD_BITS-1:0] in_key_y,
  input  logic signed [COORD_BITS-1:0] in_key_z,
  input  logic [VALUE_BITS-1:0]        in_value,
  input  sht_pkg::sht_cmd_t            cmd,
  output sht_pkg::sht_stat_t           stat,
  output logic [1:0]                   out_status,
  output logic [VALUE_BITS-1:0]        out_result_value
);
  import sht_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam bit POW2   = (SLOTS & (SLOTS - 1)) == 0;
  localparam int KEY_W  = 3 * COORD_BITS;
  localparam int ENT_W  = 2 + KEY_W + VALUE_BITS;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
  localparam logic [SLOT_W:0]   SLOT_CNT  = (SLOT_W + 1)'(SLOTS);
  localparam logic [5:0]        BIT_CNT   = 6'(HASH_W);

  logic [1:0]                   op_r;
  logic signed [COORD_BITS-1:0] kx_r, ky_r, kz_r;
  logic [VALUE_BITS-1:0]        val_r;
  logic [HASH_W-1:0]            kx32, ky32, kz32;
  logic [HASH_W-1:0]            px_r, py_r, pz_r, h_r;
  logic [HASH_W-1:0]            hash;
  logic [5:0]                   bcnt_r;
  logic [SLOT_W-1:0]            slot_r, slot_nxt, slot_inc;
  logic [SLOT_W:0]              rem_t, rem_red;
  logic [SLOT_W-1:0]            pcnt_r;
  logic [ENT_W-1:0]             mem [SLOTS];
  logic [ENT_W-1:0]             rd_r;
  logic [1:0]                   rd_tag;
  logic [COORD_BITS-1:0]        rd_kx, rd_ky, rd_kz;
  logic [VALUE_BITS-1:0]        rd_val;
  logic                         term, wr_en;
  logic [1:0]                   hit_st;
  logic [VALUE_BITS-1:0]        hit_val;
  logic [ENT_W-1:0]             wr_data;
  logic [1:0]                   status_r;
  logic [VALUE_BITS-1:0]        value_r;

  assign kx32 = HASH_W'(kx_r);
  assign ky32 = HASH_W'(ky_r);
  assign kz32 = HASH_W'(kz_r);
  assign hash = px_r ^ py_r ^ pz_r;

  assign rd_val = rd_r[VALUE_BITS-1:0];
  assign rd_kz  = rd_r[VALUE_BITS +: COORD_BITS];
  assign rd_ky  = rd_r[VALUE_BITS + COORD_BITS +: COORD_BITS];
  assign rd_kx  = rd_r[VALUE_BITS + 2 * COORD_BITS +: COORD_BITS];
  assign rd_tag = rd_r[VALUE_BITS + KEY_W +: 2];

  assign slot_inc = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
  assign rem_t    = {slot_r, h_r[HASH_W-1]};
  assign rem_red  = (rem_t >= SLOT_CNT) ? rem_t - SLOT_CNT : rem_t;

  always_comb begin
    priority if (cmd.clear || cmd.advance) begin
      slot_nxt = slot_inc;
    end else if (cmd.hash) begin
      slot_nxt = POW2 ? hash[SLOT_W-1:0] : '0;
    end else if (cmd.mod_step && !POW2) begin
      slot_nxt = rem_red[SLOT_W-1:0];
    end else begin
      slot_nxt = slot_r;
    end
  end

  always_comb begin
    term    = 1'b0;
    hit_st  = ST_MISSING;
    hit_val = '0;
    unique case (op_r)
      OP_INSERT: begin
        if (rd_tag != TAG_USED) begin
          term   = 1'b1;
          hit_st = ST_OK;
        end
      end
      OP_LOOKUP: begin
        if (rd_tag == TAG_EMPTY) begin
          term = 1'b1;
        end else if (rd_tag == TAG_USED && rd_kx == kx_r && rd_ky == ky_r && rd_kz == kz_r) begin
          term    = 1'b1;
          hit_st  = ST_OK;
          hit_val = rd_val;
        end
      end
      OP_REMOVE: begin
        if (rd_tag == TAG_EMPTY) begin
          term = 1'b1;
        end else if (rd_tag == TAG_USED && rd_val == val_r) begin
          term   = 1'b1;
          hit_st = ST_OK;
        end
      end
      default: term = 1'b1;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = {TAG_EMPTY, (ENT_W - 2)'(0)};
    if (cmd.clear) begin
      wr_en = 1'b1;
    end else if (cmd.finish && term && hit_st == ST_OK) begin
      if (op_r == OP_INSERT) begin
        wr_en   = 1'b1;
        wr_data = {TAG_USED, kx_r, ky_r, kz_r, val_r};
      end else if (op_r == OP_REMOVE) begin
        wr_en   = 1'b1;
        wr_data = {TAG_DELETED, rd_r[ENT_W-3:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot_r] <= wr_data;
    end
    rd_r <= mem[slot_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      kx_r  <= in_key_x;
      ky_r  <= in_key_y;
      kz_r  <= in_key_z;
      val_r <= in_value;
    end
    if (cmd.mul) begin
      px_r <= HASH_W'(kx32 * PRIME_X);
      py_r <= HASH_W'(ky32 * PRIME_Y);
      pz_r <= HASH_W'(kz32 * PRIME_Z);
    end
    if (cmd.hash) begin
      h_r    <= hash;
      bcnt_r <= '0;
      pcnt_r <= '0;
    end else begin
      if (cmd.mod_step) begin
        h_r    <= {h_r[HASH_W-2:0], 1'b0};
        bcnt_r <= bcnt_r + 1'b1;
      end
      if (cmd.advance) begin
        pcnt_r <= pcnt_r + 1'b1;
      end
    end
    if (cmd.finish) begin
      if (term) begin
        status_r <= hit_st;
        value_r  <= hit_val;
      end else begin
        status_r <= (op_r == OP_INSERT) ? ST_FULL : ST_MISSING;
        value_r  <= '0;
      end
    end
  end

  assign stat.mod_done   = POW2 ? 1'b1 : (bcnt_r == BIT_CNT);
  assign stat.term       = term;
  assign stat.last_probe = (pcnt_r == SLOT_LAST);
  assign stat.last_slot  = (slot_r == SLOT_LAST);

  assign out_status       = status_r;
  assign out_result_value = value_r;

endmodule

// ===== sv/sht_ctrl.sv =====
module sht_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output sht_pkg::sht_cmd_t  cmd,
  input  sht_pkg::sht_stat_t stat
);
  import sht_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MUL   = 6'b000100,
    S_HASH  = 6'b001000,
    S_MOD   = 6'b010000,
    S_PROBE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.last_slot) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_HASH;
      end
      S_HASH: begin
        cmd.hash  = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (stat.mod_done) begin
          state_nxt = S_PROBE;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_PROBE: begin
        if (stat.term || stat.last_probe) begin
          if (!out_valid_r || out_ready) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/spatial_hash_table.sv =====
// Spatial hash table: open addressing with linear probing on signed 3D keys.
// Input channel (in_valid/in_ready): one operation per transfer, in_op selects
// insert, lookup or remove by value; in_key_x/y/z and in_value carry the operands.
// Result channel (out_valid/out_ready): one transfer per operation with
// out_status (done/found, not found, table full) and out_result_value.
// After the input transfer the keys are multiplied and hashed to a home slot; the
// probe loop then reads one slot per cycle from the slot memory.
// The next input transfer can take place the cycle after the result loads.
// With a non power-of-two SLOTS the home slot reduction takes one remainder bit
// per cycle. One operation is in flight at a time.
// Reset: the block sweeps every slot to empty, one per cycle; in_ready stays
// low until the sweep ends.
// Stall: a finished result holds in the output register; the next operation
// may be accepted and hashed meanwhile, and its result waits in the probe
// stage until the previous result transfers.
module spatial_hash_table #(
  parameter int SLOTS      = 4096,
  parameter int COORD_BITS = 16,
  parameter int VALUE_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_op,
  input  logic signed [COORD_BITS-1:0] in_key_x,
  input  logic signed [COORD_BITS-1:0] in_key_y,
  input  logic signed [COORD_BITS-1:0] in_key_z,
  input  logic [VALUE_BITS-1:0]        in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [VALUE_BITS-1:0]        out_result_value
);
  import sht_pkg::*;

  sht_cmd_t  cmd;
  sht_stat_t stat;

  sht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sht_datapath #(
    .SLOTS      (SLOTS),
    .COORD_BITS (COORD_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_op            (in_op),
    .in_key_x         (in_key_x),
    .in_key_y         (in_key_y),
    .in_key_z         (in_key_z),
    .in_value         (in_value),
    .cmd              (cmd),
    .stat             (stat),
    .out_status       (out_status),
    .out_result_value (out_result_value)
  );

endmodule

// ===== verif/tb_spatial_hash_table.sv =====
module tb_spatial_hash_table;
  timeunit 1ns;
  timeprecision 1ps;

  import sht_pkg::*;

  localparam int SLOTS = 4096;
  localparam int COORD_W = 16;
  localparam int VALUE_W = 15;
  localparam int RANDOM_ITEMS = 1700;
  localparam int HOT_KEYS = 40;
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         status;
    logic [VALUE_W-1:0] value;
  } reply_t;

  typedef struct {
    logic [1:0]         op;
    logic [COORD_W-1:0] kx;
    logic [COORD_W-1:0] ky;
    logic [COORD_W-1:0] kz;
    logic [VALUE_W-1:0] v;
    bit                 pinned;
    logic [1:0]         status;
    logic [VALUE_W-1:0] value;
  } script_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 in_op = '0;
  logic signed [COORD_W-1:0]  in_key_x = '0;
  logic signed [COORD_W-1:0]  in_key_y = '0;
  logic signed [COORD_W-1:0]  in_key_z = '0;
  logic [VALUE_W-1:0]         in_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [1:0]                 out_status;
  logic [VALUE_W-1:0]         out_result_value;

  logic [1:0]           slot_tag [SLOTS];
  logic [3*COORD_W-1:0] slot_key [SLOTS];
  logic [VALUE_W-1:0]   slot_val [SLOTS];

  reply_t               pending_replies [$];
  script_row_t          script [$];
  logic [3*COORD_W-1:0] hot_keys [$];
  logic [3*COORD_W-1:0] key_log [$];
  logic [VALUE_W-1:0]   val_log [$];

  bit steady = 1'b0;
  int errors = 0;
  int cycles = 0;
  int n_ops = 0;
  int n_found = 0;
  int n_missing = 0;
  int n_full = 0;
  int n_done = 0;

  spatial_hash_table uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_key_x         (in_key_x),
    .in_key_y         (in_key_y),
    .in_key_z         (in_key_z),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_result_value (out_result_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int home_slot(input logic [COORD_W-1:0] kx, ky, kz);
    logic [31:0] h;
    h = ({{(32-COORD_W){kx[COORD_W-1]}}, kx} * PRIME_X) ^
        ({{(32-COORD_W){ky[COORD_W-1]}}, ky} * PRIME_Y) ^
        ({{(32-COORD_W){kz[COORD_W-1]}}, kz} * PRIME_Z);
    return int'(h % SLOTS);
  endfunction

  function automatic void probe_table(input logic [1:0] op,
                                      input logic [COORD_W-1:0] kx, ky, kz,
                                      input logic [VALUE_W-1:0] v,
                                      output reply_t r);
    int s;
    int n;
    s = home_slot(kx, ky, kz);
    r.status = ST_MISSING;
    r.value = '0;
    case (op)
      OP_INSERT: begin
        r.status = ST_FULL;
        for (n = 0; n < SLOTS; n++) begin
          if (slot_tag[s] != TAG_USED) begin
            slot_tag[s] = TAG_USED;
            slot_key[s] = {kx, ky, kz};
            slot_val[s] = v;
            r.status = ST_OK;
            break;
          end
          s = (s + 1) % SLOTS;
        end
      end
      OP_LOOKUP: begin
        for (n = 0; n < SLOTS; n++) begin
          if (slot_tag[s] == TAG_EMPTY) break;
          if (slot_tag[s] == TAG_USED && slot_key[s] == {kx, ky, kz}) begin
            r.status = ST_OK;
            r.value = slot_val[s];
            break;
          end
          s = (s + 1) % SLOTS;
        end
      end
      OP_REMOVE: begin
        for (n = 0; n < SLOTS; n++) begin
          if (slot_tag[s] == TAG_EMPTY) break;
          if (slot_tag[s] == TAG_USED && slot_val[s] == v) begin
            slot_tag[s] = TAG_DELETED;
            r.status = ST_OK;
            break;
          end
          s = (s + 1) % SLOTS;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_op(input logic [1:0] op, input logic [COORD_W-1:0] kx, ky, kz,
                         input logic [VALUE_W-1:0] v, input bit pinned,
                         input logic [1:0] pin_status, input logic [VALUE_W-1:0] pin_value);
    reply_t r;
    while (!steady && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_key_x <= kx;
    in_key_y <= ky;
    in_key_z <= kz;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    probe_table(op, kx, ky, kz, v, r);
    if (pinned) begin
      r.status = pin_status;
      r.value = pin_value;
    end
    n_ops++;
    if (r.status == ST_FULL) n_full++;
    else if (r.status == ST_MISSING) n_missing++;
    else if (op == OP_LOOKUP) n_found++;
    else n_done++;
    pending_replies.push_back(r);
  endtask

  task automatic random_op();
    int pick;
    int sel;
    logic [1:0] op;
    logic [3*COORD_W-1:0] k;
    logic [VALUE_W-1:0] v;
    pick = $urandom_range(99);
    sel = $urandom_range(9);
    k = {16'($urandom), 16'($urandom), 16'($urandom)};
    v = 15'($urandom);
    if (pick < 40) begin
      op = OP_INSERT;
      if (sel < 5) k = hot_keys[$urandom_range(HOT_KEYS - 1)];
      key_log.push_back(k);
      val_log.push_back(v);
    end else if (pick < 75) begin
      op = OP_LOOKUP;
      if (key_log.size() > 0 && sel < 6) begin
        k = key_log[$urandom_range(key_log.size() - 1)];
      end else if (key_log.size() > 0 && sel < 8) begin
        k = key_log[$urandom_range(key_log.size() - 1)] ^
            (48'd1 << $urandom_range(3*COORD_W - 1));
      end else if (sel < 9) begin
        k = hot_keys[$urandom_range(HOT_KEYS - 1)];
      end
    end else if (pick < 95) begin
      op = OP_REMOVE;
      if (val_log.size() > 0 && sel < 7) v = val_log[$urandom_range(val_log.size() - 1)];
      if (key_log.size() > 0 && $urandom_range(1)) begin
        k = key_log[$urandom_range(key_log.size() - 1)];
      end else if ($urandom_range(1)) begin
        k = hot_keys[$urandom_range(HOT_KEYS - 1)];
      end
    end else begin
      op = OP_UNUSED;
    end
    send_op(op, k[47:32], k[31:16], k[15:0], v, 1'b0, ST_OK, '0);
  endtask

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_replies.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: result with nothing pending: expected none, actual status=%0d value=%0d",
                 $time, out_status, out_result_value);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_status);
          errors++;
        end
        if (out_result_value !== want.value) begin
          $display("%0t: result_value mismatch: expected %0d, actual %0d",
                   $time, want.value, out_result_value);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [3*COORD_W-1:0] k;
    int i;
    for (i = 0; i < SLOTS; i++) begin
      slot_tag[i] = TAG_EMPTY;
      slot_key[i] = '0;
      slot_val[i] = '0;
    end

    // keys homed in a narrow window across the wrap point build long clusters
    while (hot_keys.size() < HOT_KEYS) begin
      k = {16'($urandom), 16'($urandom), 16'($urandom)};
      if (((home_slot(k[47:32], k[31:16], k[15:0]) + 8) % SLOTS) < 16) hot_keys.push_back(k);
    end

    script.push_back('{OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 1'b1, ST_MISSING, 15'h0});
    script.push_back('{OP_REMOVE, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 1'b1, ST_MISSING, 15'h0});
    script.push_back('{OP_UNUSED, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 1'b1, ST_MISSING, 15'h0});
    script.push_back('{OP_INSERT, 16'h8000, 16'h8000, 16'h8000, 15'h7FFF, 1'b1, ST_OK, 15'h0});
    script.push_back('{OP_LOOKUP, 16'h8000, 16'h8000, 16'h8000, 15'h0000, 1'b1, ST_OK, 15'h7FFF});
    script.push_back('{OP_INSERT, 16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h0000, 1'b1, ST_OK, 15'h0});
    script.push_back('{OP_LOOKUP, 16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF, 1'b1, ST_OK, 15'h0});
    script.push_back('{OP_INSERT, 16'h0000, 16'h0000, 16'h0000, 15'h0001, 1'b1, ST_OK, 15'h0});
    script.push_back('{OP_INSERT, 16'h0000, 16'h0000, 16'h0000, 15'h0002, 1'b1, ST_OK, 15'h0});
    script.push_back('{OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 1'b0, ST_OK, 15'h0});
    script.push_back('{OP_REMOVE, 16'h0000, 16'h0000, 16'h0000, 15'h0001, 1'b0, ST_OK, 15'h0});
    script.push_back('{OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 1'b0, ST_OK, 15'h0});
    script.push_back('{OP_INSERT, 16'h0000, 16'h0000, 16'h0000, 15'h0003, 1'b1, ST_OK, 15'h0});
    script.push_back('{OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 1'b0, ST_OK, 15'h0});
    script.push_back('{OP_REMOVE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h0002, 1'b0, ST_OK, 15'h0});
    script.push_back('{OP_REMOVE, 16'h0000, 16'h0000, 16'h0000, 15'h0002, 1'b0, ST_OK, 15'h0});
    script.push_back('{OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 1'b0, ST_OK, 15'h0});
    script.push_back('{OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h0000, 1'b0, ST_OK, 15'h0});
    script.push_back('{OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 1'b1, ST_MISSING, 15'h0});
    script.push_back('{OP_INSERT, 16'hFFFF, 16'h0000, 16'h7FFF, 15'h5555, 1'b1, ST_OK, 15'h0});
    script.push_back('{OP_LOOKUP, 16'hFFFF, 16'h0000, 16'h7FFF, 15'h2AAA, 1'b1, ST_OK, 15'h5555});
    script.push_back('{OP_UNUSED, 16'h5555, 16'hAAAA, 16'h5555, 15'h2AAA, 1'b1, ST_MISSING, 15'h0});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[j]) begin
      send_op(script[j].op, script[j].kx, script[j].ky, script[j].kz, script[j].v,
              script[j].pinned, script[j].status, script[j].value);
    end

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 700 && i < 1000);
      random_op();
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d operations over %0d cycles, with clustered keys across the wrap point.",
             n_ops, cycles);
    $display("Outcomes: %0d done, %0d found, %0d not found, %0d table full; %0d errors.",
             n_done, n_found, n_missing, n_full, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/sht_pkg.sv
sv/sht_datapath.sv
sv/sht_ctrl.sv
sv/spatial_hash_table.sv
verif/tb_spatial_hash_table.sv
